FILE: sv/mpba_pkg.sv
// Shared constants, request and status codes and control structs for the
// multi-pool block allocator. No dependencies.
`default_nettype none
package mpba_pkg;

	localparam int NUM_POOLS  = 4;
	localparam int POOL_BITS  = 2;
	localparam int BLOCK_BITS = 8;
	localparam int ADDR_BITS  = POOL_BITS + BLOCK_BITS;
	localparam int LINK_W     = 9;
	localparam int SIZE_W     = 16;
	localparam int CNT_W      = 9;
	localparam int STAT_W     = 17;
	localparam int WASTE_W    = 24;
	localparam int CTR_W      = 32;
	localparam int REQ_W      = 3;
	localparam int STS_W      = 3;
	localparam int CFG_IDX_W  = 3;

	localparam logic [LINK_W-1:0] LINK_END  = 9'd256;
	localparam logic [CNT_W-1:0]  MAX_COUNT = 9'd256;
	localparam logic [STAT_W-1:0] NO_REQ    = 17'h1FFFF;
	localparam logic [STAT_W-1:0] FAR_DIST  = 17'h10000;

	localparam logic [REQ_W-1:0] REQ_ALLOC   = 3'd0;
	localparam logic [REQ_W-1:0] REQ_FREE    = 3'd1;
	localparam logic [REQ_W-1:0] REQ_RESIZE  = 3'd2;
	localparam logic [REQ_W-1:0] REQ_TEST    = 3'd3;
	localparam logic [REQ_W-1:0] REQ_STATS   = 3'd4;
	localparam logic [REQ_W-1:0] REQ_REBUILD = 3'd5;

	localparam logic [STS_W-1:0] STS_OK    = 3'd0;
	localparam logic [STS_W-1:0] STS_ZERO  = 3'd1;
	localparam logic [STS_W-1:0] STS_NOFIT = 3'd2;
	localparam logic [STS_W-1:0] STS_FULL  = 3'd3;
	localparam logic [STS_W-1:0] STS_BAD   = 3'd4;
	localparam logic [STS_W-1:0] STS_BIG   = 3'd5;
	localparam logic [STS_W-1:0] STS_SAME  = 3'd6;

	// Index of the pool 0 block count register; lower indices are block sizes.
	localparam logic [CFG_IDX_W-1:0] CFG_COUNT_BASE = 3'd4;

	typedef struct packed {
		logic accept;
		logic fit;
		logic latch;
		logic mem_rd;
		logic sweep;
		logic exec;
	} mpba_cmd_t;

	typedef struct packed {
		logic is_rebuild;
		logic sweep_last;
	} mpba_sts_t;

endpackage
`default_nettype wire

FILE: sv/mpba_ctrl.sv
// Controller state machine of the multi-pool block allocator.
// Depends on mpba_pkg for the command and status structs.
`default_nettype none
module mpba_ctrl import mpba_pkg::*; (
	input  wire logic      clk,
	input  wire logic      arst_n,
	input  wire logic      in_valid,
	output logic           in_ready,
	output logic           out_valid,
	input  wire logic      out_ready,
	input  wire mpba_sts_t sts,
	output mpba_cmd_t      cmd
);

	localparam logic [2:0] ST_SWEEP = 3'd0;
	localparam logic [2:0] ST_IDLE  = 3'd1;
	localparam logic [2:0] ST_FIT   = 3'd2;
	localparam logic [2:0] ST_MEM   = 3'd3;
	localparam logic [2:0] ST_EXEC  = 3'd4;

	logic [2:0] state_q, state_d;
	logic       reb_q, out_valid_q;
	logic       res_free;

	assign res_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_SWEEP: begin
				cmd.sweep = 1'b1;
				if (sts.sweep_last) begin
					state_d = reb_q ? ST_EXEC : ST_IDLE;
				end
			end
			ST_IDLE: begin
				if (in_valid) begin
					cmd.accept = 1'b1;
					state_d    = ST_FIT;
				end
			end
			ST_FIT: begin
				cmd.fit = 1'b1;
				if (sts.is_rebuild) begin
					cmd.latch = 1'b1;
					state_d   = ST_SWEEP;
				end else begin
					state_d = ST_MEM;
				end
			end
			ST_MEM: begin
				cmd.mem_rd = 1'b1;
				state_d    = ST_EXEC;
			end
			ST_EXEC: begin
				if (res_free) begin
					cmd.exec = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_SWEEP;
			reb_q       <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.latch) begin
				reb_q <= 1'b1;
			end else if (state_q == ST_SWEEP && sts.sweep_last) begin
				reb_q <= 1'b0;
			end
			if (cmd.exec) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule
`default_nettype wire

FILE: sv/mpba_dp.sv
// Datapath of the multi-pool block allocator: pool registers, best-fit scan,
// link and block memories, statistics and the result register. Uses mpba_pkg.
`default_nettype none
module mpba_dp import mpba_pkg::*; (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire mpba_cmd_t            cmd,
	output mpba_sts_t                 sts,
	input  wire logic                 cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [SIZE_W-1:0]    cfg_wdata,
	input  wire logic [REQ_W-1:0]     req_type,
	input  wire logic [SIZE_W-1:0]    req_bytes,
	input  wire logic [POOL_BITS-1:0] pool_pick,
	input  wire logic [BLOCK_BITS-1:0] block_pick,
	output logic [STS_W-1:0]          status,
	output logic [POOL_BITS-1:0]      got_pool,
	output logic [BLOCK_BITS-1:0]     got_block,
	output logic [CNT_W-1:0]          used_blocks,
	output logic [CNT_W-1:0]          peak_blocks,
	output logic [SIZE_W-1:0]         least_request,
	output logic [SIZE_W-1:0]         largest_request,
	output logic [WASTE_W-1:0]        wasted_bytes,
	output logic [SIZE_W-1:0]         max_asked,
	output logic [CTR_W-1:0]          alloc_ok_count,
	output logic [CTR_W-1:0]          alloc_fail_count
);

	logic [SIZE_W-1:0]  cfg_bytes_q  [NUM_POOLS];
	logic [CNT_W-1:0]   cfg_count_q  [NUM_POOLS];
	logic [SIZE_W-1:0]  pool_bytes_q [NUM_POOLS];
	logic [CNT_W-1:0]   pool_count_q [NUM_POOLS];
	logic [LINK_W-1:0]  free_head_q  [NUM_POOLS];
	logic [CNT_W-1:0]   used_q       [NUM_POOLS];
	logic [CNT_W-1:0]   peak_q       [NUM_POOLS];
	logic [STAT_W-1:0]  min_q        [NUM_POOLS];
	logic [STAT_W-1:0]  max_q        [NUM_POOLS];
	logic [WASTE_W-1:0] waste_q      [NUM_POOLS];
	logic [SIZE_W-1:0]  largest_q;
	logic [CTR_W-1:0]   ok_q, fail_q;

	logic [REQ_W-1:0]      type_q;
	logic [SIZE_W-1:0]     bytes_q;
	logic [POOL_BITS-1:0]  pick_q;
	logic [BLOCK_BITS-1:0] blk_q;

	logic [POOL_BITS-1:0] best_s1;
	logic                 found_s1;
	logic [ADDR_BITS-1:0] addr_s1;
	logic [ADDR_BITS-1:0] sw_q;

	// Block memories: free-list links and {in use, recorded size}.
	logic [LINK_W-1:0]   link_mem [1 << ADDR_BITS];
	logic [SIZE_W:0]     use_mem  [1 << ADDR_BITS];
	logic [LINK_W-1:0]   link_rd_q;
	logic [SIZE_W:0]     use_rd_q;

	// Best-fit scan, one pool after another.
	logic [POOL_BITS-1:0] best;
	logic                 found, stop;
	logic [STAT_W-1:0]    closest, diff;

	always_comb begin
		best    = '0;
		found   = 1'b0;
		stop    = 1'b0;
		closest = FAR_DIST;
		diff    = '0;
		for (int p = 0; p < NUM_POOLS; p++) begin
			diff = {1'b0, pool_bytes_q[p]} - {1'b0, bytes_q};
			if (!stop && pool_count_q[p] != '0) begin
				if (pool_bytes_q[p] == bytes_q) begin
					if (type_q == REQ_TEST) begin
						best  = POOL_BITS'(p);
						found = 1'b1;
						stop  = 1'b1;
					end else begin
						if (!found || used_q[best] >= pool_count_q[best]) begin
							best  = POOL_BITS'(p);
							found = 1'b1;
						end
						closest = '0;
					end
				end else if (pool_bytes_q[p] > bytes_q && diff < closest) begin
					closest = diff;
					best    = POOL_BITS'(p);
					found   = 1'b1;
				end
			end
		end
	end

	// Execution of the request.
	logic [STS_W-1:0]      r_status;
	logic                  r_has;
	logic [POOL_BITS-1:0]  r_pool, pa;
	logic [BLOCK_BITS-1:0] r_block;
	logic                  do_pop, do_free, do_resize, ask_upd, fail_inc;
	logic [SIZE_W-1:0]     rec;
	logic                  inuse, blk_bad, full_b;
	logic [CNT_W-1:0]      n_used, n_peak;
	logic [STAT_W-1:0]     n_min, n_max;
	logic [WASTE_W-1:0]    n_waste;
	logic [LINK_W-1:0]     n_head;

	always_comb begin
		r_status  = STS_OK;
		r_has     = 1'b0;
		r_pool    = '0;
		r_block   = '0;
		pa        = pick_q;
		do_pop    = 1'b0;
		do_free   = 1'b0;
		do_resize = 1'b0;
		ask_upd   = 1'b0;
		fail_inc  = 1'b0;
		rec       = use_rd_q[SIZE_W-1:0];
		inuse     = use_rd_q[SIZE_W];
		blk_bad   = ({1'b0, blk_q} >= pool_count_q[pick_q]) || !inuse;
		full_b    = used_q[best_s1] >= pool_count_q[best_s1];
		case (type_q)
			REQ_ALLOC, REQ_TEST: begin
				if (bytes_q == '0) begin
					r_status = STS_ZERO;
				end else begin
					ask_upd = (type_q == REQ_ALLOC) && (bytes_q > largest_q);
					if (!found_s1) begin
						r_status = STS_NOFIT;
					end else begin
						r_has = 1'b1;
						pa    = best_s1;
						if (type_q == REQ_TEST) begin
							r_status = full_b ? STS_FULL : STS_OK;
						end else if (full_b
							|| free_head_q[best_s1] >= pool_count_q[best_s1]) begin
							r_status = STS_FULL;
							fail_inc = 1'b1;
						end else begin
							do_pop  = 1'b1;
							r_block = free_head_q[best_s1][BLOCK_BITS-1:0];
						end
					end
				end
			end
			REQ_FREE: begin
				r_has   = 1'b1;
				r_block = blk_q;
				if (blk_bad) begin
					r_status = STS_BAD;
				end else begin
					do_free = 1'b1;
				end
			end
			REQ_RESIZE: begin
				r_has   = 1'b1;
				r_block = blk_q;
				if (pool_count_q[pick_q] == '0) begin
					r_status = STS_BAD;
				end else if (bytes_q > pool_bytes_q[pick_q]) begin
					r_status = STS_BIG;
				end else if (blk_bad) begin
					r_status = STS_BAD;
				end else if (rec == bytes_q) begin
					r_status = STS_SAME;
				end else begin
					do_resize = 1'b1;
				end
			end
			REQ_STATS: begin
				r_has = 1'b1;
			end
			default: begin
				r_has = 1'b0;
			end
		endcase
		if (r_has) begin
			r_pool = pa;
		end

		n_used  = used_q[pa];
		n_peak  = peak_q[pa];
		n_min   = min_q[pa];
		n_max   = max_q[pa];
		n_waste = waste_q[pa];
		n_head  = free_head_q[pa];
		if (do_pop) begin
			n_used  = used_q[pa] + 1'b1;
			n_peak  = (n_used > peak_q[pa]) ? n_used : peak_q[pa];
			n_min   = ({1'b0, bytes_q} < min_q[pa]) ? {1'b0, bytes_q} : min_q[pa];
			n_max   = (max_q[pa] == NO_REQ || {1'b0, bytes_q} > max_q[pa])
				? {1'b0, bytes_q} : max_q[pa];
			n_waste = waste_q[pa] + WASTE_W'(pool_bytes_q[pa]) - WASTE_W'(bytes_q);
			n_head  = link_rd_q;
		end
		if (do_free) begin
			n_used  = used_q[pa] - 1'b1;
			n_waste = waste_q[pa] - WASTE_W'(pool_bytes_q[pa]) + WASTE_W'(rec);
			n_head  = {1'b0, blk_q};
		end
		if (do_resize) begin
			n_waste = waste_q[pa] + WASTE_W'(rec) - WASTE_W'(bytes_q);
		end
	end

	// Memory write port: sweep or execution.
	logic                 link_we, use_we;
	logic [ADDR_BITS-1:0] wr_addr;
	logic [LINK_W-1:0]    link_wd, sw_next;
	logic [SIZE_W:0]      use_wd;

	always_comb begin
		sw_next = {1'b0, sw_q[BLOCK_BITS-1:0]} + 1'b1;
		if (cmd.sweep) begin
			wr_addr = sw_q;
			link_we = 1'b1;
			use_we  = 1'b1;
			link_wd = (sw_next < pool_count_q[sw_q[ADDR_BITS-1:BLOCK_BITS]])
				? sw_next : LINK_END;
			use_wd  = '0;
		end else begin
			wr_addr = addr_s1;
			link_we = cmd.exec && (do_pop || do_free);
			use_we  = cmd.exec && (do_pop || do_free || do_resize);
			link_wd = do_pop ? LINK_END : free_head_q[pa];
			use_wd  = do_free ? '0 : {1'b1, bytes_q};
		end
	end

	always_ff @(posedge clk) begin
		if (link_we) begin
			link_mem[wr_addr] <= link_wd;
		end
		if (use_we) begin
			use_mem[wr_addr] <= use_wd;
		end
		if (cmd.mem_rd) begin
			link_rd_q <= link_mem[addr_s1];
			use_rd_q  <= use_mem[addr_s1];
		end
	end

	assign sts.is_rebuild = (type_q == REQ_REBUILD);
	assign sts.sweep_last = (sw_q == '1);

	// Request and scan registers.
	always_ff @(posedge clk) begin
		if (cmd.accept) begin
			type_q  <= req_type;
			bytes_q <= req_bytes;
			pick_q  <= pool_pick;
			blk_q   <= block_pick;
		end
		if (cmd.fit) begin
			best_s1  <= best;
			found_s1 <= found;
			addr_s1  <= (type_q == REQ_ALLOC)
				? {best, free_head_q[best][BLOCK_BITS-1:0]} : {pick_q, blk_q};
		end
	end

	// Block counts limited to MAX_COUNT, the 256 blocks that one pool can address.
	logic [CNT_W-1:0] sat_cnt [NUM_POOLS];

	always_comb begin
		for (int p = 0; p < NUM_POOLS; p++) begin
			sat_cnt[p] = (cfg_count_q[p] > MAX_COUNT) ? MAX_COUNT : cfg_count_q[p];
		end
	end

	// Pool state and statistics.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int p = 0; p < NUM_POOLS; p++) begin
				cfg_bytes_q[p]  <= '0;
				cfg_count_q[p]  <= '0;
				pool_bytes_q[p] <= '0;
				pool_count_q[p] <= '0;
				free_head_q[p]  <= LINK_END;
				used_q[p]       <= '0;
				peak_q[p]       <= '0;
				min_q[p]        <= NO_REQ;
				max_q[p]        <= NO_REQ;
				waste_q[p]      <= '0;
			end
			largest_q <= '0;
			ok_q      <= '0;
			fail_q    <= '0;
			sw_q      <= '0;
		end else begin
			if (cfg_wr_en) begin
				if (cfg_index < CFG_COUNT_BASE) begin
					cfg_bytes_q[cfg_index[POOL_BITS-1:0]] <= cfg_wdata;
				end else begin
					cfg_count_q[cfg_index[POOL_BITS-1:0]] <= cfg_wdata[CNT_W-1:0];
				end
			end
			if (cmd.sweep) begin
				sw_q <= sw_q + 1'b1;
			end
			if (cmd.latch) begin
				for (int p = 0; p < NUM_POOLS; p++) begin
					if (cfg_bytes_q[p] == '0 || sat_cnt[p] == '0) begin
						pool_bytes_q[p] <= '0;
						pool_count_q[p] <= '0;
						free_head_q[p]  <= LINK_END;
					end else begin
						pool_bytes_q[p] <= cfg_bytes_q[p];
						pool_count_q[p] <= sat_cnt[p];
						free_head_q[p]  <= '0;
					end
					used_q[p]  <= '0;
					peak_q[p]  <= '0;
					min_q[p]   <= NO_REQ;
					max_q[p]   <= NO_REQ;
					waste_q[p] <= '0;
				end
			end
			if (cmd.exec) begin
				used_q[pa]      <= n_used;
				peak_q[pa]      <= n_peak;
				min_q[pa]       <= n_min;
				max_q[pa]       <= n_max;
				waste_q[pa]     <= n_waste;
				free_head_q[pa] <= n_head;
				if (ask_upd) begin
					largest_q <= bytes_q;
				end
				if (do_pop) begin
					ok_q <= ok_q + 1'b1;
				end
				if (fail_inc) begin
					fail_q <= fail_q + 1'b1;
				end
			end
		end
	end

	// Result register, loaded from the updated values.
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status           <= r_status;
			got_pool         <= r_pool;
			got_block        <= r_block;
			used_blocks      <= r_has ? n_used : '0;
			peak_blocks      <= r_has ? n_peak : '0;
			least_request    <= (r_has && n_min != NO_REQ) ? n_min[SIZE_W-1:0] : '0;
			largest_request  <= (r_has && n_max != NO_REQ) ? n_max[SIZE_W-1:0] : '0;
			wasted_bytes     <= r_has ? n_waste : '0;
			max_asked        <= ask_upd ? bytes_q : largest_q;
			alloc_ok_count   <= do_pop ? ok_q + 1'b1 : ok_q;
			alloc_fail_count <= fail_inc ? fail_q + 1'b1 : fail_q;
		end
	end

endmodule
`default_nettype wire

FILE: sv/multi_pool_block_allocator.sv
// A request passes accept, best-fit scan, block memory read and execute; its result is
// registered at execute, and no new request is taken until the controller is back in idle.
// The single-port read-modify-write of the block memories sets this. Execute waits while
// the previous result is still held, so a stalled output adds its stall to the next request.
// A rebuild request sweeps all 1024 block entries, one a cycle, before its result appears;
// after an asynchronous, active-low reset the same sweep runs before any request.
`default_nettype none
module multi_pool_block_allocator import mpba_pkg::*; (
	input  wire logic                  clk,
	input  wire logic                  arst_n,
	input  wire logic                  cfg_wr_en,
	input  wire logic [CFG_IDX_W-1:0]  cfg_index,
	input  wire logic [SIZE_W-1:0]     cfg_wdata,
	input  wire logic                  in_valid,
	output logic                       in_ready,
	input  wire logic [REQ_W-1:0]      req_type,
	input  wire logic [SIZE_W-1:0]     req_bytes,
	input  wire logic [POOL_BITS-1:0]  pool_pick,
	input  wire logic [BLOCK_BITS-1:0] block_pick,
	output logic                       out_valid,
	input  wire logic                  out_ready,
	output logic [STS_W-1:0]           status,
	output logic [POOL_BITS-1:0]       got_pool,
	output logic [BLOCK_BITS-1:0]      got_block,
	output logic [CNT_W-1:0]           used_blocks,
	output logic [CNT_W-1:0]           peak_blocks,
	output logic [SIZE_W-1:0]          least_request,
	output logic [SIZE_W-1:0]          largest_request,
	output logic [WASTE_W-1:0]         wasted_bytes,
	output logic [SIZE_W-1:0]          max_asked,
	output logic [CTR_W-1:0]           alloc_ok_count,
	output logic [CTR_W-1:0]           alloc_fail_count
);

	// Configuration writes are taken at any time; they act only at the next
	// rebuild. The controller sequences each request; the datapath holds all
	// pool state, the two block memories and the result register. A result
	// waits in its register until its transfer, while the controller returns
	// to idle and may take the next request.
	mpba_cmd_t cmd;
	mpba_sts_t sts;

	mpba_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.sts       (sts),
		.cmd       (cmd)
	);

	mpba_dp u_dp (
		.clk              (clk),
		.arst_n           (arst_n),
		.cmd              (cmd),
		.sts              (sts),
		.cfg_wr_en        (cfg_wr_en),
		.cfg_index        (cfg_index),
		.cfg_wdata        (cfg_wdata),
		.req_type         (req_type),
		.req_bytes        (req_bytes),
		.pool_pick        (pool_pick),
		.block_pick       (block_pick),
		.status           (status),
		.got_pool         (got_pool),
		.got_block        (got_block),
		.used_blocks      (used_blocks),
		.peak_blocks      (peak_blocks),
		.least_request    (least_request),
		.largest_request  (largest_request),
		.wasted_bytes     (wasted_bytes),
		.max_asked        (max_asked),
		.alloc_ok_count   (alloc_ok_count),
		.alloc_fail_count (alloc_fail_count)
	);

endmodule
`default_nettype wire

FILE: sv/mpba_checker.sv
// Port-level checks for the multi-pool block allocator, bound to the top level.
// Uses mpba_pkg for field widths and status codes.
`default_nettype none
module mpba_checker import mpba_pkg::*; (
	input wire logic                   clk,
	input wire logic                   arst_n,
	input wire logic                   in_valid,
	input wire logic                   in_ready,
	input wire logic                   out_valid,
	input wire logic                   out_ready,
	input wire logic [STS_W-1:0]       status,
	input wire logic [POOL_BITS-1:0]   got_pool,
	input wire logic [BLOCK_BITS-1:0]  got_block
);

	// After a request transfer, no request is taken during the scan and memory read.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> !in_ready ##1 !in_ready)
		else $error("request taken during scan or read");

	a_status_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> status <= STS_SAME)
		else $error("status code out of range");

	a_zero_no_pool: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status == STS_ZERO || status == STS_NOFIT)
		|-> got_pool == '0 && got_block == '0)
		else $error("pool addressed on a size rejection");

	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped before transfer");

	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(status) && $stable(got_block))
		else $error("result changed before transfer");

endmodule

bind multi_pool_block_allocator mpba_checker u_mpba_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.status    (status),
	.got_pool  (got_pool),
	.got_block (got_block)
);
`default_nettype wire
